[hw/rtl/typed_chained_hash_table_top_defines.svh]
// Assertion macros shared by the hash table RTL.
// Depends on nothing; files that assert include it inside a module with aclk and aresetn.
`ifndef TYPED_CHAINED_HASH_TABLE_TOP_DEFINES_SVH
`define TYPED_CHAINED_HASH_TABLE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tcht_pkg.sv]
// Shared constants, types and the name normalization function of the hash table.
// Depends on nothing; used by every module of the block.
package tcht_pkg;

    localparam int BUCKETS     = 1024;
    localparam int MAX_ENTRIES = 4096;
    localparam int BKT_W       = $clog2(BUCKETS);
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int LINK_W      = IDX_W + 1;
    localparam int NAME_W      = 64;
    localparam int TYPE_W      = 4;
    localparam int FLAG_W      = 3;
    localparam int RES_W       = 12;
    localparam int IN_W        = 72;
    localparam int OUT_W       = 16;

    localparam logic [31:0]       HASH_K    = 32'h9E3779B1;
    localparam logic [NAME_W-1:0] NAME_DASH = 64'h2D;
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(MAX_ENTRIES);

    localparam logic [TYPE_W-1:0] T_ANY      = 4'd0;
    localparam logic [TYPE_W-1:0] T_NULL     = 4'd1;
    localparam logic [TYPE_W-1:0] T_FIRSTDEF = 4'd2;
    localparam logic [TYPE_W-1:0] T_WALL     = 4'd4;
    localparam logic [TYPE_W-1:0] T_OVERRIDE = 4'd6;
    localparam logic [TYPE_W-1:0] T_MISC     = 4'd7;

    localparam int F_RETFIRST    = 0;
    localparam int F_OVERRIDABLE = 1;
    localparam int F_TRYANY      = 2;

    typedef struct packed {
        logic [NAME_W-1:0] name;
        logic [TYPE_W-1:0] etype;
        logic [LINK_W-1:0] link;
    } entry_t;

    typedef struct packed {
        logic              bkt_we;
        logic              bkt_re;
        logic [BKT_W-1:0]  bkt_addr;
        logic [LINK_W-1:0] bkt_wdata;
        logic              ent_we;
        logic              ent_re;
        logic [IDX_W-1:0]  ent_addr;
        entry_t            ent_wdata;
    } mem_cmd_t;

    // Folds lower-case ASCII to upper case and drops everything after the first zero byte.
    function automatic logic [NAME_W-1:0] normalize(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] r;
        logic              alive;
        logic [7:0]        b;
        r     = '0;
        alive = 1'b1;
        for (int k = 0; k < 8; k++) begin
            b = raw[8*k +: 8];
            if (b == 8'h00) begin
                alive = 1'b0;
            end
            if (b >= 8'h61 && b <= 8'h7A) begin
                b = b - 8'h20;
            end
            if (alive) begin
                r[8*k +: 8] = b;
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/tcht_hash.sv]
// Multi-cycle bucket hash: fold, then a 64-bit multiply done on one shared 32x32 multiplier.
// Depends on tcht_pkg.
module tcht_hash (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [tcht_pkg::NAME_W-1:0] name,
    output logic                      done,
    output logic [tcht_pkg::BKT_W-1:0] bucket
);
    import tcht_pkg::*;

    logic              run_reg;
    logic [1:0]        ph_reg;
    logic [63:0]       x_reg;
    logic [63:0]       acc_reg;
    logic [63:0]       f1, f2, f3;
    logic [31:0]       op_a;
    logic [63:0]       prod;
    logic [63:0]       hmix;

    assign f1   = name ^ (name >> 32);
    assign f2   = f1 ^ (f1 >> 16);
    assign f3   = f2 ^ (f2 >> 8);
    assign op_a = (ph_reg == 2'd0) ? x_reg[31:0] : x_reg[63:32];
    assign prod = {32'b0, op_a} * {32'b0, HASH_K};
    assign hmix = acc_reg ^ (acc_reg >> 29);

    assign done   = run_reg && (ph_reg == 2'd2);
    assign bucket = hmix[BKT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            ph_reg  <= 2'd0;
        end else if (start) begin
            run_reg <= 1'b1;
            ph_reg  <= 2'd0;
        end else if (run_reg) begin
            if (ph_reg == 2'd2) begin
                run_reg <= 1'b0;
            end else begin
                ph_reg <= ph_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= f3;
        end else if (run_reg && ph_reg == 2'd0) begin
            acc_reg <= prod;
        end else if (run_reg && ph_reg == 2'd1) begin
            acc_reg <= acc_reg + {prod[31:0], 32'b0};
        end
    end

endmodule

[hw/rtl/tcht_store.sv]
// Bucket head memory and entry memory, each with one write and one registered read port.
// Depends on tcht_pkg.
module tcht_store (
    input  logic                       aclk,
    input  tcht_pkg::mem_cmd_t         cmd,
    output logic [tcht_pkg::LINK_W-1:0] bkt_rdata,
    output tcht_pkg::entry_t           ent_rdata
);
    import tcht_pkg::*;

    logic [LINK_W-1:0] bkt_mem [BUCKETS];
    entry_t            ent_mem [MAX_ENTRIES];

    always_ff @(posedge aclk) begin
        if (cmd.bkt_we) begin
            bkt_mem[cmd.bkt_addr] <= cmd.bkt_wdata;
        end
        if (cmd.bkt_re) begin
            bkt_rdata <= bkt_mem[cmd.bkt_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ent_we) begin
            ent_mem[cmd.ent_addr] <= cmd.ent_wdata;
        end
        if (cmd.ent_re) begin
            ent_rdata <= ent_mem[cmd.ent_addr];
        end
    end

endmodule

[hw/rtl/typed_chained_hash_table_top.sv]
// Top level of the typed chained hash table: request sequencer, chain walk and result register.
// Depends on tcht_pkg, tcht_hash, tcht_store and the assertion macro header.
// After reset the block clears all 1024 bucket heads, one per cycle, and takes no request
// until all of them are cleared. An insert of a non-empty name passes through the hash,
// which uses the shared hash multiplier. A lookup passes through the hash and then reads
// the chain one entry at a time, each entry read going through the registered memory
// port, with a final S_FINISH step when no entry matches.
// Lookups of an empty name or of "-", inserts of an empty name and refused inserts skip
// the hash. A new request is taken while the previous result waits in the output
// register; a result that finds that register still occupied holds the block until
// m_tready rises.
module typed_chained_hash_table_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[0], key_name[64:1], use_type[68:65], match_flags[71:69]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_index[11:0], found[12], table_full[13], zero[15:14]
    output logic [15:0] m_tdata
);
    import tcht_pkg::*;
    `include "typed_chained_hash_table_top_defines.svh"

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_HASH   = 9'b000000100,
        S_HEAD   = 9'b000001000,
        S_EREQ   = 9'b000010000,
        S_ECMP   = 9'b000100000,
        S_FINISH = 9'b001000000,
        S_OUT    = 9'b010000000,
        S_WAIT   = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [BKT_W-1:0]  clr_reg;
    logic [LINK_W-1:0] count_reg;
    logic              op_reg;
    logic [NAME_W-1:0] name_reg;
    logic [TYPE_W-1:0] ut_reg;
    logic [FLAG_W-1:0] fl_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [LINK_W-1:0] cur_reg;
    logic [LINK_W-1:0] guard_reg;
    logic              fvalid_reg;
    logic [IDX_W-1:0]  fidx_reg;
    logic [TYPE_W-1:0] ftype_reg;
    logic [IDX_W-1:0]  ridx_reg;
    logic              rfound_reg;
    logic              rfull_reg;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    logic              in_op;
    logic [NAME_W-1:0] in_name;
    logic [TYPE_W-1:0] in_ut;
    logic [FLAG_W-1:0] in_fl;
    logic              accept;
    logic              hash_start;
    logic              hash_done;
    logic [BKT_W-1:0]  hash_bkt;
    mem_cmd_t          cmd;
    logic [LINK_W-1:0] bkt_rdata;
    entry_t            ent_rdata;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              take_first;
    logic [IDX_W-1:0]  cur_idx;
    logic              full;

    assign in_op   = s_tdata[0];
    assign in_name = normalize(s_tdata[64:1]);
    assign in_ut   = s_tdata[68:65];
    assign in_fl   = s_tdata[71:69];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = count_reg[IDX_W];
    assign cur_idx  = cur_reg[IDX_W-1:0];

    assign hash_start = accept && (in_name != '0)
                        && (in_op ? !full : (in_name != NAME_DASH));

    tcht_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .name    (in_name),
        .done    (hash_done),
        .bucket  (hash_bkt)
    );

    tcht_store u_store (
        .aclk      (aclk),
        .cmd       (cmd),
        .bkt_rdata (bkt_rdata),
        .ent_rdata (ent_rdata)
    );

    always_comb begin
        hit        = 1'b0;
        hit_idx    = '0;
        take_first = 1'b0;
        if (ent_rdata.name == name_reg) begin
            if (ut_reg == T_ANY) begin
                hit = 1'b1;
                if (!(ent_rdata.etype == T_FIRSTDEF && !fl_reg[F_RETFIRST])
                        && ent_rdata.etype != T_NULL) begin
                    hit_idx = cur_idx;
                end
            end else if (fl_reg[F_OVERRIDABLE] && ent_rdata.etype == T_OVERRIDE) begin
                hit     = 1'b1;
                hit_idx = cur_idx;
            end else if (ent_rdata.etype == ut_reg) begin
                hit     = 1'b1;
                hit_idx = cur_idx;
            end else if (ent_rdata.etype == T_FIRSTDEF && ut_reg == T_WALL) begin
                hit = 1'b1;
                if (fl_reg[F_RETFIRST]) begin
                    hit_idx = cur_idx;
                end
            end else if (ent_rdata.etype == T_NULL && ut_reg == T_WALL) begin
                hit = 1'b1;
            end else if (ftype_reg == T_NULL || (ftype_reg == T_MISC
                         && ent_rdata.etype != ftype_reg && ent_rdata.etype != T_NULL)) begin
                take_first = 1'b1;
            end
        end
    end

    always_comb begin
        cmd           = '0;
        cmd.bkt_addr  = bkt_reg;
        cmd.ent_addr  = cur_idx;
        cmd.ent_wdata = '{name: name_reg, etype: ut_reg, link: bkt_rdata};
        cmd.bkt_wdata = count_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.bkt_we    = 1'b1;
                cmd.bkt_addr  = clr_reg;
                cmd.bkt_wdata = LINK_NONE;
            end
            S_IDLE: begin
                cmd.ent_addr  = count_reg[IDX_W-1:0];
                cmd.ent_wdata = '{name: in_name, etype: in_ut, link: LINK_NONE};
                cmd.ent_we    = accept && in_op && !full && (in_name == '0);
            end
            S_HASH: begin
                cmd.bkt_addr = hash_bkt;
                cmd.bkt_re   = hash_done;
            end
            S_HEAD: begin
                cmd.ent_addr = count_reg[IDX_W-1:0];
                cmd.ent_we   = op_reg;
                cmd.bkt_we   = op_reg;
            end
            S_EREQ: begin
                cmd.ent_re = !cur_reg[IDX_W] && !guard_reg[IDX_W];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (&clr_reg) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = hash_start ? S_HASH : S_OUT;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                state_next = op_reg ? S_OUT : S_EREQ;
            end
            S_EREQ: begin
                state_next = (cur_reg[IDX_W] || guard_reg[IDX_W]) ? S_FINISH : S_ECMP;
            end
            S_ECMP: begin
                state_next = hit ? S_OUT : S_EREQ;
            end
            S_FINISH: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                state_next = (!m_tvalid_reg || m_tready) ? S_IDLE : S_WAIT;
            end
            S_WAIT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            count_reg    <= LINK_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + BKT_W'(1);
            end
            if (cmd.ent_we) begin
                count_reg <= count_reg + LINK_W'(1);
            end
            if ((state_reg == S_OUT || state_reg == S_WAIT) && state_next == S_IDLE) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= in_op;
            name_reg   <= in_name;
            ut_reg     <= in_ut;
            fl_reg     <= in_fl;
            guard_reg  <= '0;
            fvalid_reg <= 1'b0;
            ftype_reg  <= T_NULL;
            rfull_reg  <= in_op && full;
            rfound_reg <= in_op ? !full : (in_name == NAME_DASH);
            ridx_reg   <= (in_op && !full) ? count_reg[IDX_W-1:0] : '0;
        end
        if (hash_done) begin
            bkt_reg <= hash_bkt;
        end
        if (state_reg == S_HEAD) begin
            cur_reg <= bkt_rdata;
        end
        if (state_reg == S_ECMP) begin
            if (hit) begin
                ridx_reg   <= hit_idx;
                rfound_reg <= 1'b1;
            end else begin
                if (take_first) begin
                    fvalid_reg <= 1'b1;
                    fidx_reg   <= cur_idx;
                    ftype_reg  <= ent_rdata.etype;
                end
                cur_reg   <= ent_rdata.link;
                guard_reg <= guard_reg + LINK_W'(1);
            end
        end
        if (state_reg == S_FINISH) begin
            if (fl_reg[F_TRYANY] && ut_reg != T_ANY && fvalid_reg) begin
                rfound_reg <= 1'b1;
                if (ftype_reg != T_NULL
                        && !(ftype_reg == T_FIRSTDEF && !fl_reg[F_RETFIRST])) begin
                    ridx_reg <= fidx_reg;
                end
            end
        end
        if ((state_reg == S_OUT || state_reg == S_WAIT) && state_next == S_IDLE) begin
            m_tdata_reg <= {2'b00, rfull_reg, rfound_reg, RES_W'(ridx_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `TCHT_ASSERT_NOW(a_count_range, 1'b1, count_reg <= LINK_W'(MAX_ENTRIES), "entry count overflow")
    `TCHT_ASSERT_NEXT(a_busy_after_accept, accept, state_reg != S_IDLE, "idle right after request")
    `TCHT_ASSERT_NEXT(a_insert_count, state_reg == S_HEAD && op_reg, count_reg == $past(count_reg) + LINK_W'(1), "insert did not advance count")
    `TCHT_ASSERT_NOW(a_no_walk_on_insert, state_reg == S_EREQ || state_reg == S_ECMP, !op_reg, "chain walk during insert")

endmodule
